@@ rtl/ptcp_pkg.sv @@
`timescale 1ns / 1ps

package ptcp_pkg;

  localparam int LINE_MAX    = 64;
  localparam int LINE_CNT_W  = $clog2(LINE_MAX);
  localparam int ANGLE_W     = 8;
  localparam int PULSE_W     = 12;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_DATA_W  = 48;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_HOME    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_HOME   = 3'd4;

  localparam logic [7:0] RST_LEVEL_ONE   = 8'd30;
  localparam logic [7:0] RST_LEVEL_TWO   = 8'd20;
  localparam logic [7:0] RST_LEVEL_THREE = 8'd10;
  localparam logic [7:0] RST_PAN_HOME    = 8'd0;
  localparam logic [7:0] RST_TILT_HOME   = 8'd90;
  localparam logic [7:0] RST_TILT_ANGLE  = 8'd90;

  // characters
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_AT  = 8'h40;
  localparam logic [7:0] CH_R   = 8'h52;
  localparam logic [7:0] CH_1   = 8'h31;
  localparam logic [7:0] CH_2   = 8'h32;
  localparam logic [7:0] CH_3   = 8'h33;
  localparam logic [7:0] CH_Q   = 8'h51;
  localparam logic [7:0] CH_W   = 8'h57;
  localparam logic [7:0] CH_E   = 8'h45;
  localparam logic [7:0] CH_A   = 8'h41;
  localparam logic [7:0] CH_D   = 8'h44;
  localparam logic [7:0] CH_Z   = 8'h5A;
  localparam logic [7:0] CH_X   = 8'h58;
  localparam logic [7:0] CH_C   = 8'h43;

  typedef enum logic [2:0] {
    ST_ABSORB   = 3'd0,
    ST_APPLY    = 3'd1,
    ST_HOME     = 3'd2,
    ST_ERROR    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] level_one;
    logic [7:0] level_two;
    logic [7:0] level_three;
    logic [7:0] pan_home;
    logic [7:0] tilt_home;
  } cfg_t;

  // parser result stage handed to the output register
  typedef struct packed {
    logic               valid;
    logic [ANGLE_W-1:0] pan;
    logic [ANGLE_W-1:0] tilt;
    status_t            status;
  } stage_t;

  // 500 + angle*2000/180 rounded down; angle*100/9 taken as angle*100*ceil(2^16/9) >> 16,
  // exact for every 8-bit angle
  function automatic logic [PULSE_W-1:0] pulse_of(input logic [ANGLE_W-1:0] a);
    logic [27:0] prod;
    prod = 28'(a) * 28'd728200;
    return PULSE_W'(500) + prod[27:16];
  endfunction

endpackage

@@ rtl/ptcp_cfg.sv @@
`timescale 1ns / 1ps

module ptcp_cfg
  import ptcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [CFG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx   = paddr[CFG_ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_LEVEL_ONE:   cfg_nxt.level_one   = pwdata[7:0];
        REG_LEVEL_TWO:   cfg_nxt.level_two   = pwdata[7:0];
        REG_LEVEL_THREE: cfg_nxt.level_three = pwdata[7:0];
        REG_PAN_HOME:    cfg_nxt.pan_home    = pwdata[7:0];
        REG_TILT_HOME:   cfg_nxt.tilt_home   = pwdata[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_one   <= RST_LEVEL_ONE;
      cfg_r.level_two   <= RST_LEVEL_TWO;
      cfg_r.level_three <= RST_LEVEL_THREE;
      cfg_r.pan_home    <= RST_PAN_HOME;
      cfg_r.tilt_home   <= RST_TILT_HOME;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_LEVEL_ONE:   prdata = CFG_DATA_W'(cfg_r.level_one);
      REG_LEVEL_TWO:   prdata = CFG_DATA_W'(cfg_r.level_two);
      REG_LEVEL_THREE: prdata = CFG_DATA_W'(cfg_r.level_three);
      REG_PAN_HOME:    prdata = CFG_DATA_W'(cfg_r.pan_home);
      REG_TILT_HOME:   prdata = CFG_DATA_W'(cfg_r.tilt_home);
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/ptcp_parse.sv @@
`timescale 1ns / 1ps

module ptcp_parse
  import ptcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic       advance,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output stage_t     stage
);

  typedef enum logic [2:0] {
    PH_BEFORE,
    PH_FIRST,
    PH_BETWEEN,
    PH_SECOND,
    PH_DONE,
    PH_DEAD
  } phase_t;

  logic [LINE_CNT_W-1:0] line_cnt_r, line_cnt_nxt;
  phase_t                phase_r, phase_nxt;
  logic [7:0]            first_char_r, first_char_nxt;
  logic [7:0]            area_char_r, area_char_nxt;
  logic [7:0]            level_char_r, level_char_nxt;
  logic [1:0]            level_len_r, level_len_nxt;
  logic                  text_long_r, text_long_nxt;
  logic [ANGLE_W-1:0]    pan_r, pan_nxt;
  logic [ANGLE_W-1:0]    tilt_r, tilt_nxt;
  status_t               status_r, status_nxt;
  logic                  valid_r, valid_nxt;

  logic [7:0]            step;
  logic [ANGLE_W:0]      pan_sum, tilt_sum;
  logic [ANGLE_W-1:0]    pan_up, pan_dn, tilt_up, tilt_dn;
  logic                  level_ok;

  always_comb begin
    case (level_char_r)
      CH_1:    step = cfg.level_one;
      CH_2:    step = cfg.level_two;
      default: step = cfg.level_three;
    endcase
  end

  // saturating moves
  assign pan_sum  = {1'b0, pan_r} + {1'b0, step};
  assign tilt_sum = {1'b0, tilt_r} + {1'b0, step};
  assign pan_up   = (pan_sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : pan_sum[ANGLE_W-1:0];
  assign tilt_up  = (tilt_sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : tilt_sum[ANGLE_W-1:0];
  assign pan_dn   = (pan_r >= step) ? pan_r - step : '0;
  assign tilt_dn  = (tilt_r >= step) ? tilt_r - step : '0;

  assign level_ok = (phase_r == PH_SECOND || phase_r == PH_DONE) && level_len_r == 2'd1 &&
                    level_char_r >= CH_1 && level_char_r <= CH_3;

  always_comb begin
    line_cnt_nxt   = line_cnt_r;
    phase_nxt      = phase_r;
    first_char_nxt = first_char_r;
    area_char_nxt  = area_char_r;
    level_char_nxt = level_char_r;
    level_len_nxt  = level_len_r;
    text_long_nxt  = text_long_r;
    pan_nxt        = pan_r;
    tilt_nxt       = tilt_r;
    status_nxt     = ST_ABSORB;

    if (rx_byte == CH_CR) begin
      status_nxt = ST_ABSORB;
    end else if (rx_byte == CH_LF) begin
      if (line_cnt_r != '0) begin
        if (first_char_r == CH_R && !text_long_r) begin
          pan_nxt    = (cfg.pan_home > ANGLE_MAX) ? ANGLE_MAX : cfg.pan_home;
          tilt_nxt   = (cfg.tilt_home > ANGLE_MAX) ? ANGLE_MAX : cfg.tilt_home;
          status_nxt = ST_HOME;
        end else if (level_ok) begin
          status_nxt = ST_APPLY;
          case (area_char_r)
            CH_Q: begin
              pan_nxt  = pan_up;
              tilt_nxt = tilt_dn;
            end
            CH_W: pan_nxt = pan_up;
            CH_E: begin
              pan_nxt  = pan_up;
              tilt_nxt = tilt_up;
            end
            CH_A: tilt_nxt = tilt_dn;
            CH_D: tilt_nxt = tilt_up;
            CH_Z: begin
              pan_nxt  = pan_dn;
              tilt_nxt = tilt_dn;
            end
            CH_X: pan_nxt = pan_dn;
            CH_C: begin
              pan_nxt  = pan_dn;
              tilt_nxt = tilt_up;
            end
            default: pan_nxt = pan_r;
          endcase
        end else begin
          status_nxt = ST_ERROR;
        end
        line_cnt_nxt   = '0;
        phase_nxt      = PH_BEFORE;
        first_char_nxt = '0;
        area_char_nxt  = '0;
        level_char_nxt = '0;
        level_len_nxt  = '0;
        text_long_nxt  = 1'b0;
      end
    end else if (line_cnt_r >= LINE_CNT_W'(LINE_MAX - 1)) begin
      // line too long: drop it and start over
      status_nxt     = ST_OVERFLOW;
      line_cnt_nxt   = '0;
      phase_nxt      = PH_BEFORE;
      first_char_nxt = '0;
      area_char_nxt  = '0;
      level_char_nxt = '0;
      level_len_nxt  = '0;
      text_long_nxt  = 1'b0;
    end else begin
      if (line_cnt_r == '0) begin
        first_char_nxt = rx_byte;
      end else if (line_cnt_r == LINE_CNT_W'(1) && rx_byte != CH_NUL &&
                   first_char_r != CH_NUL) begin
        text_long_nxt = 1'b1;
      end
      line_cnt_nxt = line_cnt_r + LINE_CNT_W'(1);

      if (rx_byte == CH_NUL) begin
        // a nul ends the line text
        if (phase_r == PH_SECOND) begin
          phase_nxt = PH_DONE;
        end else if (phase_r != PH_DONE) begin
          phase_nxt = PH_DEAD;
        end
      end else begin
        case (phase_r)
          PH_BEFORE: begin
            if (rx_byte != CH_AT) begin
              area_char_nxt = rx_byte;
              phase_nxt     = PH_FIRST;
            end
          end
          PH_FIRST: begin
            if (rx_byte == CH_AT) begin
              phase_nxt = PH_BETWEEN;
            end
          end
          PH_BETWEEN: begin
            if (rx_byte != CH_AT) begin
              level_char_nxt = rx_byte;
              level_len_nxt  = 2'd1;
              phase_nxt      = PH_SECOND;
            end
          end
          PH_SECOND: begin
            if (rx_byte == CH_AT) begin
              phase_nxt = PH_DONE;
            end else if (level_len_r != 2'd3) begin
              level_len_nxt = level_len_r + 2'd1;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r   <= '0;
      phase_r      <= PH_BEFORE;
      first_char_r <= '0;
      area_char_r  <= '0;
      level_char_r <= '0;
      level_len_r  <= '0;
      text_long_r  <= 1'b0;
      pan_r        <= '0;
      tilt_r       <= RST_TILT_ANGLE;
      status_r     <= ST_ABSORB;
      valid_r      <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (take) begin
        line_cnt_r   <= line_cnt_nxt;
        phase_r      <= phase_nxt;
        first_char_r <= first_char_nxt;
        area_char_r  <= area_char_nxt;
        level_char_r <= level_char_nxt;
        level_len_r  <= level_len_nxt;
        text_long_r  <= text_long_nxt;
        pan_r        <= pan_nxt;
        tilt_r       <= tilt_nxt;
        status_r     <= status_nxt;
      end
    end
  end

  assign stage.valid  = valid_r;
  assign stage.pan    = pan_r;
  assign stage.tilt   = tilt_r;
  assign stage.status = status_r;

endmodule

@@ rtl/ptcp_out.sv @@
`timescale 1ns / 1ps

module ptcp_out
  import ptcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  stage_t                stage,
  input  logic                  out_ready,
  output logic                  advance,
  output logic                  out_valid,
  output logic [OUT_DATA_W-1:0] out_data
);

  logic               valid_r;
  logic [PULSE_W-1:0] pan_pulse_r, tilt_pulse_r;
  logic [ANGLE_W-1:0] pan_angle_r, tilt_angle_r;
  status_t            status_r;

  // output register is free or being emptied this cycle
  assign advance = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.valid) begin
      pan_pulse_r  <= pulse_of(stage.pan);
      tilt_pulse_r <= pulse_of(stage.tilt);
      pan_angle_r  <= stage.pan;
      tilt_angle_r <= stage.tilt;
      status_r     <= stage.status;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = {5'b0, status_r, tilt_angle_r, pan_angle_r, tilt_pulse_r, pan_pulse_r};

endmodule

@@ rtl/pan_tilt_command_parser_core.sv @@
`timescale 1ns / 1ps

// Pan/tilt command parser: one received character per input word, one result word per
// input word. Throughput is one word per clock while out_tready stays high; a word's
// result passes through the parser register, which also holds the line state and the
// servo angles, and then the output register, where the pulse widths are computed.
// in_tready drops only when both registers hold words that have not yet been taken.
// Configuration is read and written through the cfg_ port at byte addresses 0, 4, 8,
// 12 and 16 (three step sizes, pan home, tilt home).

module pan_tilt_command_parser_core
  import ptcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [11:0] pan_pulse, [23:12] tilt_pulse, [31:24] pan_angle, [39:32] tilt_angle,
  // [42:40] line_status, [47:43] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t   cfg;
  stage_t stage;
  logic   advance;
  logic   take;

  assign cfg_pready = 1'b1;
  assign in_tready  = !stage.valid || advance;
  assign take       = in_tvalid && in_tready;

  ptcp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  ptcp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .advance (advance),
    .rx_byte (in_tdata),
    .cfg     (cfg),
    .stage   (stage)
  );

  ptcp_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .out_ready (out_tready),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_data  (out_tdata)
  );

endmodule

@@ rtl/ptcp_checker.sv @@
`timescale 1ns / 1ps

module ptcp_checker
  import ptcp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[42:40] <= ST_OVERFLOW)
    else $error("line status out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:24] <= 8'd180 && out_tdata[39:32] <= 8'd180)
    else $error("angle above 180");

  // pan pulse must follow its angle at the low end of the range, tilt pulse at the high end
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[31:24] == 8'd0) == (out_tdata[11:0] == 12'd500)) &&
                   ((out_tdata[39:32] == 8'd180) == (out_tdata[23:12] == 12'd2500)))
    else $error("pulse width does not match angle");

endmodule

bind pan_tilt_command_parser_core ptcp_checker u_ptcp_checker (.*);

@@ tb/pan_tilt_command_parser_checker.sv @@
`timescale 1ns / 1ps

module pan_tilt_command_parser_checker
  import ptcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    mismatch_count,
  output int                    results_owed
);

  typedef enum logic [2:0] {
    SEEK_DIR,
    IN_DIR,
    SEEK_LEVEL,
    IN_LEVEL,
    LEVEL_DONE,
    LINE_DEAD
  } token_phase_t;

  typedef struct {
    logic [PULSE_W-1:0] pan_pulse;
    logic [PULSE_W-1:0] tilt_pulse;
    logic [ANGLE_W-1:0] pan_angle;
    logic [ANGLE_W-1:0] tilt_angle;
    status_t            status;
  } servo_word_t;

  servo_word_t servo_word_q[$];

  cfg_t               regs;
  int                 chars_held;
  token_phase_t       phase;
  logic [7:0]         lead_char;
  logic [7:0]         dir_char;
  logic [7:0]         level_digit;
  int                 level_len;
  bit                 text_long;
  logic [ANGLE_W-1:0] pan_deg;
  logic [ANGLE_W-1:0] tilt_deg;

  function automatic logic [ANGLE_W-1:0] sat_up(input logic [7:0] a, input logic [7:0] d);
    int s;
    s = int'(a) + int'(d);
    return (s > 180) ? ANGLE_MAX : ANGLE_W'(s);
  endfunction

  function automatic logic [ANGLE_W-1:0] sat_down(input logic [7:0] a, input logic [7:0] d);
    return (a >= d) ? a - d : '0;
  endfunction

  function automatic logic [PULSE_W-1:0] pulse_us(input logic [ANGLE_W-1:0] a);
    return PULSE_W'(500 + (int'(a) * 2000) / 180);
  endfunction

  function automatic void clear_line();
    chars_held  = 0;
    phase       = SEEK_DIR;
    lead_char   = '0;
    dir_char    = '0;
    level_digit = '0;
    level_len   = 0;
    text_long   = 1'b0;
  endfunction

  function automatic void move_servos(input logic [7:0] dir, input logic [7:0] d);
    case (dir)
      CH_Q: begin
        pan_deg  = sat_up(pan_deg, d);
        tilt_deg = sat_down(tilt_deg, d);
      end
      CH_W: pan_deg = sat_up(pan_deg, d);
      CH_E: begin
        pan_deg  = sat_up(pan_deg, d);
        tilt_deg = sat_up(tilt_deg, d);
      end
      CH_A: tilt_deg = sat_down(tilt_deg, d);
      CH_D: tilt_deg = sat_up(tilt_deg, d);
      CH_Z: begin
        pan_deg  = sat_down(pan_deg, d);
        tilt_deg = sat_down(tilt_deg, d);
      end
      CH_X: pan_deg = sat_down(pan_deg, d);
      CH_C: begin
        pan_deg  = sat_down(pan_deg, d);
        tilt_deg = sat_up(tilt_deg, d);
      end
      default: ;
    endcase
  endfunction

  function automatic status_t finish_line();
    status_t    st;
    logic [7:0] step;
    if (chars_held == 0) begin
      return ST_ABSORB;
    end
    if (lead_char == CH_R && !text_long) begin
      pan_deg  = (regs.pan_home > ANGLE_MAX) ? ANGLE_MAX : regs.pan_home;
      tilt_deg = (regs.tilt_home > ANGLE_MAX) ? ANGLE_MAX : regs.tilt_home;
      st = ST_HOME;
    end else if ((phase == IN_LEVEL || phase == LEVEL_DONE) && level_len == 1 &&
                 level_digit >= CH_1 && level_digit <= CH_3) begin
      step = (level_digit == CH_1) ? regs.level_one :
             (level_digit == CH_2) ? regs.level_two : regs.level_three;
      move_servos(dir_char, step);
      st = ST_APPLY;
    end else begin
      st = ST_ERROR;
    end
    clear_line();
    return st;
  endfunction

  function automatic void collect_char(input logic [7:0] b);
    if (chars_held == 0) begin
      lead_char = b;
    end else if (chars_held == 1 && b != CH_NUL && lead_char != CH_NUL) begin
      text_long = 1'b1;
    end
    chars_held++;
    // a nul ends the line text, later bytes only count toward the length
    if (b == CH_NUL) begin
      if (phase == IN_LEVEL) begin
        phase = LEVEL_DONE;
      end else if (phase != LEVEL_DONE) begin
        phase = LINE_DEAD;
      end
      return;
    end
    case (phase)
      SEEK_DIR: begin
        if (b != CH_AT) begin
          dir_char = b;
          phase    = IN_DIR;
        end
      end
      IN_DIR: begin
        if (b == CH_AT) phase = SEEK_LEVEL;
      end
      SEEK_LEVEL: begin
        if (b != CH_AT) begin
          level_digit = b;
          level_len   = 1;
          phase       = IN_LEVEL;
        end
      end
      IN_LEVEL: begin
        if (b == CH_AT) begin
          phase = LEVEL_DONE;
        end else if (level_len < 3) begin
          level_len++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic servo_word_t parse_byte(input logic [7:0] b);
    servo_word_t w;
    status_t     st;
    st = ST_ABSORB;
    if (b == CH_CR) begin
      st = ST_ABSORB;
    end else if (b == CH_LF) begin
      st = finish_line();
    end else if (chars_held >= LINE_MAX - 1) begin
      clear_line();
      st = ST_OVERFLOW;
    end else begin
      collect_char(b);
    end
    w.pan_pulse  = pulse_us(pan_deg);
    w.tilt_pulse = pulse_us(tilt_deg);
    w.pan_angle  = pan_deg;
    w.tilt_angle = tilt_deg;
    w.status     = st;
    return w;
  endfunction

  function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    case (idx)
      REG_LEVEL_ONE:   regs.level_one   = v;
      REG_LEVEL_TWO:   regs.level_two   = v;
      REG_LEVEL_THREE: regs.level_three = v;
      REG_PAN_HOME:    regs.pan_home    = v;
      REG_TILT_HOME:   regs.tilt_home   = v;
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    servo_word_t exp_w;
    logic [PULSE_W-1:0] got_pan_pulse;
    logic [PULSE_W-1:0] got_tilt_pulse;
    logic [ANGLE_W-1:0] got_pan;
    logic [ANGLE_W-1:0] got_tilt;
    logic [2:0]         got_status;
    if (!rst_n) begin
      regs.level_one   = RST_LEVEL_ONE;
      regs.level_two   = RST_LEVEL_TWO;
      regs.level_three = RST_LEVEL_THREE;
      regs.pan_home    = RST_PAN_HOME;
      regs.tilt_home   = RST_TILT_HOME;
      clear_line();
      pan_deg  = '0;
      tilt_deg = RST_TILT_ANGLE;
      servo_word_q.delete();
      mismatch_count = 0;
    end else begin
      // check the outgoing word first: an incoming word cannot leave in the same cycle
      if (out_tvalid && out_tready) begin
        got_pan_pulse  = out_tdata[11:0];
        got_tilt_pulse = out_tdata[23:12];
        got_pan        = out_tdata[31:24];
        got_tilt       = out_tdata[39:32];
        got_status     = out_tdata[42:40];
        if (servo_word_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result word with nothing expected, data %h", $realtime, out_tdata);
          end
        end else begin
          exp_w = servo_word_q.pop_front();
          if (got_pan_pulse !== exp_w.pan_pulse || got_tilt_pulse !== exp_w.tilt_pulse ||
              got_pan !== exp_w.pan_angle || got_tilt !== exp_w.tilt_angle ||
              got_status !== exp_w.status) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display({"%0t: mismatch exp pulse %0d/%0d angle %0d/%0d status %0d,",
                        " got %0d/%0d %0d/%0d %0d"},
                       $realtime, exp_w.pan_pulse, exp_w.tilt_pulse, exp_w.pan_angle,
                       exp_w.tilt_angle, exp_w.status, got_pan_pulse, got_tilt_pulse,
                       got_pan, got_tilt, got_status);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        servo_word_q.push_back(parse_byte(in_tdata));
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        write_reg(cfg_paddr[CFG_ADDR_W-1:2], cfg_pwdata[7:0]);
      end
    end
    results_owed = servo_word_q.size();
  end

endmodule

@@ tb/pan_tilt_command_parser_core_tb.sv @@
`timescale 1ns / 1ps

module pan_tilt_command_parser_core_tb;
  import ptcp_pkg::*;

  localparam int                   STALL_LIMIT    = 2000;
  localparam int                   HOLD_CYCLES    = 200;
  localparam int                   WORDS_PER_STEP = 325;
  localparam logic [7:0]           CH_S           = 8'h53;
  localparam logic [7:0]           CH_0           = 8'h30;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 3'd5;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int mismatch_count;
  int results_owed;
  int words_sent   = 0;
  int src_gap_mode = 1;
  int stall_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pan_tilt_command_parser_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pan_tilt_command_parser_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // 0: back to back, 1: a random gap, possibly none, before each word, 2: mostly back to back with an occasional gap
  function automatic int draw_gap(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 16);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : 0;
    endcase
  endfunction

  function automatic logic [7:0] dir_letter(input int k);
    case (k)
      0:       return CH_Q;
      1:       return CH_W;
      2:       return CH_E;
      3:       return CH_A;
      4:       return CH_S;
      5:       return CH_D;
      6:       return CH_Z;
      7:       return CH_X;
      default: return CH_C;
    endcase
  endfunction

  // any byte that is not a line control or token separator
  function automatic logic [7:0] rand_glyph();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_LF || b == CH_CR || b == CH_AT || b == CH_NUL) begin
      b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  function automatic logic [7:0] rand_not_lf();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_LF) begin
      b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (words_sent % 64 == 0) begin
      src_gap_mode = $urandom_range(0, 2);
    end
    gap = draw_gap(src_gap_mode);
    @(negedge clk);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  task automatic send_random_line();
    logic [7:0] txt[$];
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      if ($urandom_range(0, 7) == 0) txt.push_back(CH_AT);
      if ($urandom_range(0, 9) == 0) begin
        txt.push_back(rand_glyph());
      end else begin
        txt.push_back(dir_letter($urandom_range(0, 8)));
      end
      if ($urandom_range(0, 5) == 0) txt.push_back(rand_glyph());
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
      repeat (n) txt.push_back(CH_AT);
      case ($urandom_range(0, 9))
        0: txt.push_back(CH_0 + 8'($urandom_range(0, 9)));
        1: begin
          txt.push_back(CH_1 + 8'($urandom_range(0, 2)));
          txt.push_back(CH_0 + 8'($urandom_range(0, 9)));
        end
        2: txt.push_back(rand_glyph());
        default: txt.push_back(CH_1 + 8'($urandom_range(0, 2)));
      endcase
      if ($urandom_range(0, 4) == 0) begin
        txt.push_back(CH_AT);
        repeat ($urandom_range(1, 3)) txt.push_back(rand_glyph());
      end
      if ($urandom_range(0, 19) == 0) begin
        txt[$urandom_range(0, txt.size() - 1)] = CH_NUL;
      end
    end else if (pick < 72) begin
      txt.push_back(CH_R);
      case ($urandom_range(0, 5))
        0: txt.push_back(rand_glyph());
        1: txt.push_back(CH_NUL);
        2: begin
          txt.push_back(CH_AT);
          txt.push_back(CH_1);
        end
        default: ;
      endcase
    end else if (pick < 92) begin
      repeat ($urandom_range(0, 10)) txt.push_back(rand_not_lf());
    end else begin
      // long enough to run past the line buffer, or stop near its edge
      repeat ($urandom_range(58, 70)) txt.push_back(rand_not_lf());
    end
    txt.push_back(CH_LF);
    foreach (txt[i]) begin
      if ($urandom_range(0, 14) == 0) send_byte(CH_CR);
      send_byte(txt[i]);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'd0, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_steps_homes(input logic [7:0] s1, input logic [7:0] s2,
                                 input logic [7:0] s3, input logic [7:0] ph,
                                 input logic [7:0] th);
    cfg_write(REG_LEVEL_ONE, s1);
    cfg_write(REG_LEVEL_TWO, s2);
    cfg_write(REG_LEVEL_THREE, s3);
    cfg_write(REG_PAN_HOME, ph);
    cfg_write(REG_TILT_HOME, th);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result side: random stalls, plus two long hold-offs so the input backs up
  initial begin
    int gap;
    int taken;
    int mode;
    taken = 0;
    mode  = 1;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (taken % 50 == 0) mode = $urandom_range(0, 2);
      gap = (taken == 150 || taken == 900) ? HOLD_CYCLES : draw_gap(mode);
      repeat (gap) begin
        out_tready <= 1'b0;
        @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("pan_tilt_command_parser_core_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty line, home, a move, extra tokens, unknown direction, leading nul, all-ones byte
    send_text("\r\n");
    send_text("R\n");
    send_text("Q@1\n");
    send_text("C@@3@9\n");
    send_text("K@2\n");
    send_byte(CH_NUL);
    send_text("W@1\n");
    send_byte(8'hFF);
    send_text("\n");

    for (int step = 0; step < 6; step++) begin
      if (step > 0) begin
        drain();
        case (step)
          1: set_steps_homes(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
          2: begin
            set_steps_homes(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
            cfg_write(REG_UNUSED, 8'd7);
          end
          3: set_steps_homes(8'd180, 8'd1, 8'd90, 8'd180, 8'd180);
          default: set_steps_homes(8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 180)));
        endcase
      end
      while (words_sent < (step + 1) * WORDS_PER_STEP) send_random_line();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("pan_tilt_command_parser_core_tb OK");
    end else begin
      $display("pan_tilt_command_parser_core_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ptcp_pkg.sv
rtl/ptcp_cfg.sv
rtl/ptcp_parse.sv
rtl/ptcp_out.sv
rtl/pan_tilt_command_parser_core.sv
rtl/ptcp_checker.sv
tb/pan_tilt_command_parser_checker.sv
tb/pan_tilt_command_parser_core_tb.sv
